[src/bfk4_pkg.sv]
// Shared types and constants for the four-hash Bloom filter.
package bfk4_pkg;

    typedef logic [31:0] word_t;

    localparam int NUM_HASH = 4;
    localparam int DEF_ARRAY_BYTES = 16;

    localparam word_t MX_PRIME  = 32'h811C_9DC5;
    localparam word_t FNV_MULT  = 32'd16777619;
    localparam word_t FNV_BASIS = 32'd2166136261;
    localparam word_t BKDR_SEED = 32'd131;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

endpackage

[src/bloom_filter_four_hash.sv]
// Top level of the four-hash Bloom filter with its bit-array memory.
// Non-final key bytes are taken one per cycle. A final byte blocks the input until its
// result is loaded: 5 avalanche steps, the remainder unit, the bit-memory accesses,
// then the load of the result register.
// A result held off by m_tready holds the input off as well. After reset the bit
// memory is cleared one entry per cycle, all ARRAY_BYTES*8 entries, before any transaction.
module bloom_filter_four_hash
    import bfk4_pkg::*;
#(
    parameter int ARRAY_BYTES = DEF_ARRAY_BYTES
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] key_byte
    input  logic [0:0] s_tuser,   // [0] op
    input  logic       s_tlast,   // last_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [0] maybe_present, [7:1] zero
    output logic [0:0] m_tuser    // [0] done_op
);

    localparam int NUM_BITS = ARRAY_BYTES * 8;
    localparam int IDX_W = $clog2(NUM_BITS);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_BITS - 1);

    // sequencer
    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_AVAL   = 3'd2;
    localparam logic [2:0] ST_MOD    = 3'd3;
    localparam logic [2:0] ST_ACCESS = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    localparam logic [2:0] AVAL_LAST = 3'd4;
    localparam logic [2:0] ACC_LAST  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [2:0]       cnt_reg, cnt_next;
    logic [IDX_W-1:0] clr_cnt_reg;

    // running hashes
    word_t mx_reg, fnv_reg, sdbm_reg, bkdr_reg;
    word_t mx_next, fnv_next, sdbm_next, bkdr_next;
    word_t key_ext;

    // finished hashes of the current key; lane 1 gets the avalanche
    word_t work_reg [NUM_HASH];
    word_t aval_out;
    word_t mod_x [NUM_HASH];
    logic  mod_start;
    logic  mod_done;
    logic [IDX_W-1:0] idx [NUM_HASH];

    logic op_reg;
    logic hit_reg;

    // bit array: one write and one registered read per cycle
    logic             mem [NUM_BITS];
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic             mem_wdata;
    logic [IDX_W-1:0] mem_raddr;
    logic             rdata_reg;

    // result register
    logic out_valid_reg;
    logic out_hit_reg;
    logic out_op_reg;
    logic out_load;

    logic in_xact;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xact  = s_tvalid && s_tready;

    // per-byte hash update, byte sign-extended
    always_comb
    begin
        key_ext   = {{24{s_tdata[7]}}, s_tdata};
        mx_next   = (mx_reg * MX_PRIME) ^ key_ext;
        fnv_next  = (fnv_reg * FNV_MULT) ^ key_ext;
        sdbm_next = key_ext + (sdbm_reg << 6) + (sdbm_reg << 16) - sdbm_reg;
        bkdr_next = bkdr_reg * BKDR_SEED + key_ext;
    end

    // one avalanche step per cycle
    always_comb
    begin
        case (cnt_reg)
            3'd0:    aval_out = work_reg[1] + (work_reg[1] << 13);
            3'd1:    aval_out = work_reg[1] ^ (work_reg[1] >> 7);
            3'd2:    aval_out = work_reg[1] + (work_reg[1] << 3);
            3'd3:    aval_out = work_reg[1] ^ (work_reg[1] >> 17);
            3'd4:    aval_out = work_reg[1] + (work_reg[1] << 5);
            default: aval_out = work_reg[1];
        endcase
    end

    // remainder unit starts on the last avalanche step, fed the stepped value
    assign mod_start = (state_reg == ST_AVAL) && (cnt_reg == AVAL_LAST);

    always_comb
    begin
        mod_x    = work_reg;
        mod_x[1] = aval_out;
    end

    bfk4_mod_unit #(
        .NUM_BITS (NUM_BITS)
    ) u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .x     (mod_x),
        .done  (mod_done),
        .rem   (idx)
    );

    // memory port control
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx[cnt_reg[1:0]];
        mem_wdata = 1'b1;
        mem_raddr = idx[cnt_reg[1:0]];
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = 1'b0;
        end
        else if (state_reg == ST_ACCESS && op_reg == OP_ADD && cnt_reg != ACC_LAST)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == IDX_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_xact && s_tlast)
                begin
                    state_next = ST_AVAL;
                    cnt_next   = '0;
                end
            end
            ST_AVAL:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == AVAL_LAST)
                begin
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                if (mod_done)
                begin
                    state_next = ST_ACCESS;
                    cnt_next   = '0;
                end
            end
            ST_ACCESS:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ACC_LAST)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            clr_cnt_reg   <= '0;
            mx_reg        <= '0;
            fnv_reg       <= FNV_BASIS;
            sdbm_reg      <= '0;
            bkdr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            // running hashes restart after the final byte of a key
            if (in_xact)
            begin
                if (s_tlast)
                begin
                    mx_reg   <= '0;
                    fnv_reg  <= FNV_BASIS;
                    sdbm_reg <= '0;
                    bkdr_reg <= '0;
                end
                else
                begin
                    mx_reg   <= mx_next;
                    fnv_reg  <= fnv_next;
                    sdbm_reg <= sdbm_next;
                    bkdr_reg <= bkdr_next;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_xact && s_tlast)
        begin
            work_reg[0] <= mx_next;
            work_reg[1] <= fnv_next;
            work_reg[2] <= sdbm_next;
            work_reg[3] <= bkdr_next;
            op_reg      <= s_tuser[0];
        end
        else if (state_reg == ST_AVAL)
        begin
            work_reg[1] <= aval_out;
        end
        // read data is registered, so it lags its address
        if (state_reg == ST_MOD)
        begin
            hit_reg <= 1'b1;
        end
        else if (state_reg == ST_ACCESS && cnt_reg != 3'd0)
        begin
            hit_reg <= hit_reg & rdata_reg;
        end
        if (out_load)
        begin
            out_hit_reg <= (op_reg == OP_QUERY) ? hit_reg : 1'b0;
            out_op_reg  <= op_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_hit_reg};
    assign m_tuser  = out_op_reg;

    a_mod_done_in_mod: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> state_reg == ST_MOD)
        else $error("remainder done outside its wait state");

    a_add_reports_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] == OP_ADD |-> m_tdata[0] == 1'b0)
        else $error("add transaction reports a hit");

    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> state_reg == ST_CLEAR
            || (state_reg == ST_ACCESS && op_reg == OP_ADD))
        else $error("bit memory written outside clear or add");

    a_access_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ACCESS && cnt_reg == ACC_LAST |=> state_reg == ST_DONE)
        else $error("memory access phase overran");

endmodule

[src/bfk4_mod_unit.sv]
// Four-lane remainder unit: word mod NUM_BITS by reciprocal multiply and one correction.
module bfk4_mod_unit
    import bfk4_pkg::*;
#(
    parameter int NUM_BITS = DEF_ARRAY_BYTES * 8
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  word_t                       x [NUM_HASH],
    output logic                        done,
    output logic [$clog2(NUM_BITS)-1:0] rem [NUM_HASH]
);

    localparam int IDX_W = $clog2(NUM_BITS);
    localparam logic [IDX_W:0] NB = (IDX_W + 1)'(NUM_BITS);
    // floor(2^32 / NUM_BITS): the quotient estimate is low by at most one
    localparam word_t RECIP = word_t'(64'h1_0000_0000 / 64'(NUM_BITS));

    word_t            x_reg [NUM_HASH];
    word_t            q_reg [NUM_HASH];
    word_t            q_next [NUM_HASH];
    logic [IDX_W-1:0] r_reg [NUM_HASH];
    logic [IDX_W-1:0] r_next [NUM_HASH];
    logic             mul_vld_reg;
    logic             fix_vld_reg;
    logic             done_reg;

    // quotient estimate
    always_comb
    begin
        logic [63:0] prod;
        for (int l = 0; l < NUM_HASH; l++)
        begin
            prod      = {32'd0, x_reg[l]} * {32'd0, RECIP};
            q_next[l] = prod[63:32];
        end
    end

    // remainder estimate lies in [0, 2*NUM_BITS), so the low bits suffice
    always_comb
    begin
        logic [IDX_W:0] t;
        for (int l = 0; l < NUM_HASH; l++)
        begin
            t = x_reg[l][IDX_W:0] - q_reg[l][IDX_W:0] * NB;
            if (t >= NB)
            begin
                t = t - NB;
            end
            r_next[l] = t[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_vld_reg <= 1'b0;
            fix_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            mul_vld_reg <= start;
            fix_vld_reg <= mul_vld_reg;
            done_reg    <= fix_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < NUM_HASH; l++)
        begin
            if (start)
            begin
                x_reg[l] <= x[l];
            end
            if (mul_vld_reg)
            begin
                q_reg[l] <= q_next[l];
            end
            if (fix_vld_reg)
            begin
                r_reg[l] <= r_next[l];
            end
        end
    end

    assign done = done_reg;
    assign rem  = r_reg;

endmodule
